### sv/fp32_narrowing_converter_core_defines.svh
// Assertion macros for the narrowing converter
`ifndef FP32_NARROWING_CONVERTER_CORE_DEFINES_SVH
`define FP32_NARROWING_CONVERTER_CORE_DEFINES_SVH
// Check a property on every rising clock edge outside reset
`define FNC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that one condition implies another in the next cycle
`define FNC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

### sv/fnc_pkg.sv
// Package: format codes and shared constants of the narrowing converter
package fnc_pkg;
    typedef enum logic [1:0] {
        FMT_HALF = 2'd0,
        FMT_BF16 = 2'd1,
        FMT_E4M3 = 2'd2,
        FMT_E5M2 = 2'd3
    } fmt_t;
    localparam logic [15:0] HALF_INF = 16'h7c00;
    localparam logic [15:0] BF16_QUIET = 16'h0040;
    localparam logic [7:0] E4M3_NAN = 8'h7f;
    localparam logic [7:0] E5M2_NAN = 8'h7e;
    localparam logic [7:0] E4M3_MAX = 8'h7e;
    localparam logic [7:0] E5M2_MAX = 8'h7b;
endpackage

### sv/fnc_convert.sv
// Combinational conversion of one binary32 pattern to the selected narrow format
module fnc_convert import fnc_pkg::*; (
    input  logic [31:0] single_bits,
    input  fmt_t        fmt,
    output logic [15:0] narrow_bits
);
    // round a 24-bit significand right by shift, nearest even
    function automatic logic [23:0] rshift(input logic [23:0] sig, input logic [5:0] sh);
        logic [47:0] wide;
        logic [23:0] kept;
        logic        g;
        logic        st;
        begin
            if (sh == 6'd0) begin
                rshift = sig;
            end else if (sh >= 6'd26) begin
                rshift = 24'd0;
            end else begin
                wide = {sig, 24'd0} >> sh;
                kept = wide[47:24];
                g = wide[23];
                st = |wide[22:0];
                rshift = kept + {23'd0, g & (st | kept[0])};
            end
        end
    endfunction

    logic        sgn;
    logic [7:0]  ebits;
    logic [22:0] mant;
    logic [23:0] sig;
    logic [15:0] half_r;
    logic [15:0] bf_r;
    logic [7:0]  e4_r;
    logic [7:0]  e5_r;
    logic [9:0]  hpay;
    logic [15:0] hcode;
    logic [23:0] hsub;
    logic [31:0] bfsum;
    logic [8:0]  e4n;
    logic [8:0]  e5n;
    logic [8:0]  e4sh;
    logic [8:0]  e5sh;
    logic [23:0] e4c;
    logic [23:0] e5c;

    assign sgn = single_bits[31];
    assign ebits = single_bits[30:23];
    assign mant = single_bits[22:0];
    assign sig = {(ebits != 8'd0), mant};

    // half precision
    always_comb begin
        hpay = (mant[22:13] == 10'd0) ? 10'd1 : mant[22:13];
        hcode = {1'b0, 5'(ebits - 8'd112), mant[22:13]};
        hcode = hcode + {15'd0, mant[12] & ((|mant[11:0]) | hcode[0])};
        hsub = rshift({1'b1, mant}, 6'(8'd126 - ebits));
        if (ebits == 8'hff) begin
            half_r = {sgn, 15'd0} | HALF_INF | ((mant == 23'd0) ? 16'd0 : {6'd0, hpay});
        end else if (ebits >= 8'd143) begin
            half_r = {sgn, 15'd0} | HALF_INF;
        end else if (ebits <= 8'd112) begin
            if (ebits < 8'd102) half_r = {sgn, 15'd0};
            else half_r = {sgn, 15'd0} | hsub[15:0];
        end else if (hcode >= HALF_INF) begin
            half_r = {sgn, 15'd0} | HALF_INF;
        end else begin
            half_r = {sgn, 15'd0} | hcode;
        end
    end

    // bfloat16
    always_comb begin
        bfsum = single_bits + 32'h7fff + {31'd0, single_bits[16]};
        if (ebits == 8'hff && mant != 23'd0) bf_r = single_bits[31:16] | BF16_QUIET;
        else bf_r = bfsum[31:16];
    end

    // fp8: normal range rounds the mantissa tail; below it, shift by 20 or 21 plus (1 - te),
    // clamped so that very small values flush to zero
    always_comb begin
        e4n = {1'b0, ebits} - 9'd120;
        e5n = {1'b0, ebits} - 9'd112;
        e4sh = 9'd141 - {1'b0, (ebits == 8'd0) ? 8'd1 : ebits};
        e5sh = 9'd134 - {1'b0, (ebits == 8'd0) ? 8'd1 : ebits};
        if (ebits > 8'd120)
            e4c = ({15'd0, e4n} << 3) + rshift({1'b0, mant}, 6'd20);
        else
            e4c = rshift(sig, (e4sh >= 9'd26) ? 6'd26 : e4sh[5:0]);
        if (ebits > 8'd112)
            e5c = ({15'd0, e5n} << 2) + rshift({1'b0, mant}, 6'd21);
        else
            e5c = rshift(sig, (e5sh >= 9'd26) ? 6'd26 : e5sh[5:0]);
        if (ebits == 8'hff) begin
            e4_r = (mant != 23'd0) ? E4M3_NAN : ({sgn, 7'd0} | E4M3_MAX);
            e5_r = (mant != 23'd0) ? E5M2_NAN : ({sgn, 7'd0} | E5M2_MAX);
        end else begin
            e4_r = {sgn, 7'd0} | ((e4c > 24'(E4M3_MAX)) ? E4M3_MAX : e4c[7:0]);
            e5_r = {sgn, 7'd0} | ((e5c > 24'(E5M2_MAX)) ? E5M2_MAX : e5c[7:0]);
        end
    end

    // select format
    always_comb begin
        case (fmt)
            FMT_HALF: narrow_bits = half_r;
            FMT_BF16: narrow_bits = bf_r;
            FMT_E4M3: narrow_bits = {8'd0, e4_r};
            FMT_E5M2: narrow_bits = {8'd0, e5_r};
            default:  narrow_bits = half_r;
        endcase
    end
endmodule

### sv/fp32_narrowing_converter_core.sv
// Top level: registered single-pass binary32 narrowing converter
// Each beat passes the input register, then the result register; conversion is one pass
// of logic between them. Throughput: one beat per cycle while the output is not stalled.
// A held result stalls the input only when the result register stays full and stalled.
// Reset clears valid flags and selects half precision.
module fp32_narrowing_converter_core import fnc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] single_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] narrow_bits
);
`include "fp32_narrowing_converter_core_defines.svh"
    fmt_t        fmt_reg;
    logic        s1_valid_reg;
    logic [31:0] s1_bits_reg;
    logic        s2_valid_reg;
    logic [15:0] s2_bits_reg;
    logic [15:0] conv;
    logic        s2_free;
    logic        s1_free;

    assign s2_free = !s2_valid_reg || !out_stall;
    assign s1_free = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign out_valid = s2_valid_reg;
    assign narrow_bits = s2_bits_reg;

    // hold format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fmt_reg <= FMT_HALF;
        else if (cfg_we) fmt_reg <= fmt_t'(cfg_wdata);
    end

    fnc_convert u_conv (.single_bits(s1_bits_reg), .fmt(fmt_reg), .narrow_bits(conv));

    // advance pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free) s1_valid_reg <= in_valid;
            if (s2_free) s2_valid_reg <= s1_valid_reg;
        end
    end

    // load payloads
    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid) s1_bits_reg <= single_bits;
        if (s2_free && s1_valid_reg) s2_bits_reg <= conv;
    end

    `FNC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(narrow_bits),
        "stalled result changed")
    `FNC_ASSERT(a_stall, in_stall |-> (s1_valid_reg && s2_valid_reg), "stall without full pipe")
    `FNC_ASSERT_NEXT(a_adv, s1_valid_reg && !in_stall, out_valid, "item lost in pipeline")
endmodule
